@@ src/wfdm_pkg.sv @@
// shared types, constants and register codes for the wall-following drive mixer
package wfdm_pkg;

    // default build values
    localparam int unsigned PWM_MAX_DEF    = 255;
    localparam int unsigned ANGLE_BITS_DEF = 12;

    // quarter-wave sine polynomial coefficients, q16
    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [15:0] SIN_B = 16'd42048;
    localparam logic [12:0] SIN_C = 13'd4640;

    // heading rate limit in mrad/s
    localparam logic [10:0] RATE_LIMIT = 11'd2000;

    // rounded divide by 1000 through a reciprocal, floor(2^20 / 1000)
    localparam logic [9:0]  HALF_1000  = 10'd500;
    localparam logic [9:0]  K_1000     = 10'd1000;
    localparam logic [10:0] RECIP_1000 = 11'd1048;

    // input queue depth
    localparam int unsigned QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REF_OFFSET  = 3'd0,
        REG_GAIN        = 3'd1,
        REG_BASE_SPEED  = 3'd2,
        REG_MAX_SPEED   = 3'd3,
        REG_SENSOR_FWD  = 3'd4,
        REG_SENSOR_SIDE = 3'd5,
        REG_HALF_TRACK  = 3'd6
    } t_reg_idx;

    // configuration register file contents
    typedef struct packed {
        logic        [11:0] ref_offset;
        logic        [11:0] gain;
        logic signed [11:0] base_speed;
        logic        [10:0] max_speed;
        logic signed [9:0]  sensor_fwd;
        logic signed [9:0]  sensor_side;
        logic        [8:0]  half_track;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        ref_offset:  12'd500,
        gain:        12'd512,
        base_speed:  12'sd100,
        max_speed:   11'd500,
        sensor_fwd:  10'sd0,
        sensor_side: 10'sd0,
        half_track:  9'd75
    };

    // drive command codes
    typedef enum logic [1:0] {
        CMD_FORWARD  = 2'd0,
        CMD_BACKWARD = 2'd1,
        CMD_RIGHT    = 2'd2,
        CMD_LEFT     = 2'd3
    } t_drive_cmd;

    // back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_X2,
        ST_T,
        ST_U,
        ST_S,
        ST_OFF,
        ST_ERR,
        ST_GAIN,
        ST_RATE,
        ST_DPROD,
        ST_DEST,
        ST_DCOR,
        ST_WHEEL,
        ST_NUM,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

@@ src/wfdm_front.sv @@
// front end: accepts requests, rescales the heading and folds it into sine and cosine quadrants
module wfdm_front
    import wfdm_pkg::*;
#(
    parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [15:0]      i_pos,
    input  logic        [11:0]      i_heading,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [15:0]      o_pos,
    output logic [ANGLE_BITS-2:0]   o_ks,
    output logic [ANGLE_BITS-2:0]   o_kc,
    output logic                    o_neg_s,
    output logic                    o_neg_c
);

    localparam int unsigned QW  = ANGLE_BITS - 2;
    localparam int unsigned SHL = (ANGLE_BITS >= 12) ? ANGLE_BITS - 12 : 0;
    localparam int unsigned SHR = (ANGLE_BITS < 12) ? 12 - ANGLE_BITS : 0;
    localparam int unsigned AW  = 12 + SHL;
    localparam logic [QW:0]           QSIZE = {1'b1, {QW{1'b0}}};
    localparam logic [ANGLE_BITS-1:0] QTURN = {2'b01, {QW{1'b0}}};

    logic [AW-1:0]         w_a_wide;
    logic [ANGLE_BITS-1:0] w_a;
    logic [ANGLE_BITS-1:0] w_ac;
    logic [QW:0]           w_ks;
    logic [QW:0]           w_kc;
    logic                  r_valid;

    // heading rescaled to the ANGLE_BITS angle resolution
    assign w_a_wide = (AW'(i_heading) << SHL) >> SHR;
    assign w_a      = w_a_wide[ANGLE_BITS-1:0];
    assign w_ac     = w_a + QTURN;

    // mirror odd quadrants onto the rising quarter wave
    assign w_ks = w_a[ANGLE_BITS-2]  ? QSIZE - {1'b0, w_a[QW-1:0]}  : {1'b0, w_a[QW-1:0]};
    assign w_kc = w_ac[ANGLE_BITS-2] ? QSIZE - {1'b0, w_ac[QW-1:0]} : {1'b0, w_ac[QW-1:0]};

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // classified request payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            o_pos   <= i_pos;
            o_ks    <= w_ks;
            o_kc    <= w_kc;
            o_neg_s <= w_a[ANGLE_BITS-1];
            o_neg_c <= w_ac[ANGLE_BITS-1];
        end
    end

endmodule

@@ src/wfdm_queue.sv @@
// short request queue between the front end and the back end
module wfdm_queue
    import wfdm_pkg::*;
#(
    parameter int unsigned WIDTH = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int unsigned DEPTH = QUEUE_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ src/wfdm_back.sv @@
// back end: sequencer for sine, error, rate, wheel mixing and pwm division, with output register
module wfdm_back
    import wfdm_pkg::*;
#(
    parameter int unsigned PWM_MAX    = PWM_MAX_DEF,
    parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [15:0]    i_pos,
    input  logic [ANGLE_BITS-2:0] i_ks,
    input  logic [ANGLE_BITS-2:0] i_kc,
    input  logic                  i_neg_s,
    input  logic                  i_neg_c,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_cmd,
    output logic [7:0]            o_pwm,
    output logic signed [8:0]     o_steer,
    output logic signed [11:0]    o_rate,
    output logic signed [11:0]    o_left,
    output logic signed [11:0]    o_right,
    output logic signed [15:0]    o_err
);

    localparam int unsigned QW    = ANGLE_BITS - 2;
    localparam int unsigned PW    = $clog2(PWM_MAX + 1);
    localparam int unsigned NQE   = PW + (PW % 2);
    localparam int unsigned NW    = 11 + PW;
    localparam int unsigned STEPS = NQE / 2;
    localparam int unsigned CW    = $clog2(STEPS + 1);
    localparam logic [PW-1:0] PWM_K = PW'(PWM_MAX);

    // one restoring division step: {quotient bit, remainder}
    function automatic logic [11:0] div_step(input logic [10:0] rem, input logic nb,
                                             input logic [10:0] dv);
        logic [11:0] trial;
        logic [11:0] diff;
        trial = {rem, nb};
        diff  = trial - {1'b0, dv};
        if (trial >= {1'b0, dv}) begin
            return {1'b1, diff[10:0]};
        end else begin
            return {1'b0, trial[10:0]};
        end
    endfunction

    // wheel speed limited to plus or minus the maximum
    function automatic logic signed [11:0] clamp_speed(input logic signed [12:0] v,
                                                       input logic signed [12:0] m);
        logic signed [12:0] r;
        if (v > m) begin
            r = m;
        end else if (v < -m) begin
            r = -m;
        end else begin
            r = v;
        end
        return 12'(r);
    endfunction

    t_back_state r_state;
    t_back_state n_state;

    logic w_pop;
    logic w_out_free;
    logic w_out_load;

    // datapath registers
    logic signed [15:0] r_pos;
    logic               r_neg_s;
    logic               r_neg_c;
    logic [16:0]        r_x_s;
    logic [16:0]        r_x_c;
    logic [16:0]        r_x2_s;
    logic [16:0]        r_x2_c;
    logic [15:0]        r_t_s;
    logic [15:0]        r_t_c;
    logic [16:0]        r_u_s;
    logic [16:0]        r_u_c;
    logic signed [17:0] r_sin;
    logic signed [17:0] r_cos;
    logic signed [12:0] r_off;
    logic signed [15:0] r_err;
    logic signed [28:0] r_gp;
    logic signed [11:0] r_rate;
    logic [19:0]        r_dmag;
    logic               r_dneg;
    logic [19:0]        r_n;
    logic [10:0]        r_q0;
    logic signed [11:0] r_d;
    logic signed [11:0] r_vl;
    logic signed [11:0] r_vr;
    logic [10:0]        r_rem_l;
    logic [10:0]        r_rem_r;
    logic [NQE-1:0]     r_nlo_l;
    logic [NQE-1:0]     r_nlo_r;
    logic [NQE-1:0]     r_quo_l;
    logic [NQE-1:0]     r_quo_r;
    logic [CW-1:0]      r_cnt;

    // output register
    logic               r_o_valid;
    t_drive_cmd         r_o_cmd;
    logic [7:0]         r_o_pwm;
    logic signed [8:0]  r_o_steer;
    logic signed [11:0] r_o_rate;
    logic signed [11:0] r_o_vl;
    logic signed [11:0] r_o_vr;
    logic signed [15:0] r_o_err;

    // step results
    logic [33:0]        w_sq_s;
    logic [33:0]        w_sq_c;
    logic [29:0]        w_cx_s;
    logic [29:0]        w_cx_c;
    logic [32:0]        w_xt_s;
    logic [32:0]        w_xt_c;
    logic [33:0]        w_xu_s;
    logic [33:0]        w_xu_c;
    logic [16:0]        w_sm;
    logic [16:0]        w_cm;
    logic signed [27:0] w_pf;
    logic signed [27:0] w_ps;
    logic signed [28:0] w_psum;
    logic signed [18:0] w_e;
    logic signed [15:0] w_esat;
    logic [28:0]        w_gabs;
    logic [28:0]        w_grnd;
    logic [20:0]        w_gq;
    logic [10:0]        w_rmag;
    logic signed [11:0] w_rate;
    logic [10:0]        w_rabs;
    logic [19:0]        w_n;
    logic [30:0]        w_qp;
    logic [20:0]        w_qk;
    logic [20:0]        w_rdiff;
    logic [10:0]        w_dm;
    logic [10:0]        w_maxs;
    logic signed [12:0] w_maxs13;
    logic signed [12:0] w_sl;
    logic signed [12:0] w_sr;
    logic [10:0]        w_av_l;
    logic [10:0]        w_av_r;
    logic [NW-1:0]      w_num_l;
    logic [NW-1:0]      w_num_r;
    logic [11:0]        w_st1_l;
    logic [11:0]        w_st2_l;
    logic [11:0]        w_st1_r;
    logic [11:0]        w_st2_r;
    logic [PW-1:0]      w_pl;
    logic [PW-1:0]      w_pr;
    logic [PW-1:0]      w_big;
    logic signed [PW:0] w_steer;
    t_drive_cmd         w_cmd;

    // quarter-wave polynomial, both lanes
    assign w_sq_s = r_x_s * r_x_s;
    assign w_sq_c = r_x_c * r_x_c;
    assign w_cx_s = SIN_C * r_x2_s;
    assign w_cx_c = SIN_C * r_x2_c;
    assign w_xt_s = r_x2_s * r_t_s;
    assign w_xt_c = r_x2_c * r_t_c;
    assign w_xu_s = r_x_s * r_u_s;
    assign w_xu_c = r_x_c * r_u_c;
    assign w_sm   = (w_xu_s[33:16] > 18'd65536) ? 17'd65536 : w_xu_s[32:16];
    assign w_cm   = (w_xu_c[33:16] > 18'd65536) ? 17'd65536 : w_xu_c[32:16];

    // sensor lateral offset, rounded to nearest with halves upward
    assign w_pf   = r_sin * $signed(i_cfg.sensor_fwd);
    assign w_ps   = r_cos * $signed(i_cfg.sensor_side);
    assign w_psum = 29'(w_pf) + 29'(w_ps) + 29'sd32768;

    // lateral error, saturated to 16 bits
    assign w_e    = $signed({7'b0, i_cfg.ref_offset}) - 19'(r_pos) - 19'(r_off);
    assign w_esat = (w_e > 19'sd32767)  ? 16'sh7FFF :
                    (w_e < -19'sd32768) ? 16'sh8000 : 16'(w_e);

    // heading rate: gain times error over 256, rounded half away from zero, clamped
    assign w_gabs = r_gp[28] ? 29'(-r_gp) : 29'(r_gp);
    assign w_grnd = w_gabs + 29'd128;
    assign w_gq   = w_grnd[28:8];
    assign w_rmag = (w_gq > 21'(RATE_LIMIT)) ? RATE_LIMIT : w_gq[10:0];
    assign w_rate = r_gp[28] ? -$signed({1'b0, w_rmag}) : $signed({1'b0, w_rmag});
    assign w_rabs = r_rate[11] ? 11'(-r_rate) : 11'(r_rate);

    // wheel differential: rounded divide by 1000 through reciprocal and one correction
    assign w_n     = r_dmag + 20'(HALF_1000);
    assign w_qp    = w_n * RECIP_1000;
    assign w_qk    = r_q0 * K_1000;
    assign w_rdiff = {1'b0, r_n} - w_qk;
    assign w_dm    = r_q0 + 11'(w_rdiff >= 21'(K_1000));

    // wheel mixing and clamp
    assign w_maxs   = (i_cfg.max_speed == '0) ? 11'd1 : i_cfg.max_speed;
    assign w_maxs13 = $signed({2'b0, w_maxs});
    assign w_sl     = 13'($signed(i_cfg.base_speed)) - 13'(r_d);
    assign w_sr     = 13'($signed(i_cfg.base_speed)) + 13'(r_d);

    // pwm numerators
    assign w_av_l  = 11'(r_vl[11] ? -r_vl : r_vl);
    assign w_av_r  = 11'(r_vr[11] ? -r_vr : r_vr);
    assign w_num_l = w_av_l * PWM_K;
    assign w_num_r = w_av_r * PWM_K;

    // two division steps per cycle on each wheel
    assign w_st1_l = div_step(r_rem_l, r_nlo_l[NQE-1], w_maxs);
    assign w_st2_l = div_step(w_st1_l[10:0], r_nlo_l[NQE-2], w_maxs);
    assign w_st1_r = div_step(r_rem_r, r_nlo_r[NQE-1], w_maxs);
    assign w_st2_r = div_step(w_st1_r[10:0], r_nlo_r[NQE-2], w_maxs);

    // final pwm, steering and command
    assign w_pl    = (r_quo_l > NQE'(PWM_K)) ? PWM_K : PW'(r_quo_l);
    assign w_pr    = (r_quo_r > NQE'(PWM_K)) ? PWM_K : PW'(r_quo_r);
    assign w_big   = (w_pl > w_pr) ? w_pl : w_pr;
    assign w_steer = $signed({1'b0, w_pr}) - $signed({1'b0, w_pl});

    always_comb begin
        priority if (!r_vl[11] && !r_vr[11]) begin
            w_cmd = CMD_FORWARD;
        end else if (r_vl[11] && r_vr[11]) begin
            w_cmd = CMD_BACKWARD;
        end else if (r_vl > r_vr) begin
            w_cmd = CMD_RIGHT;
        end else begin
            w_cmd = CMD_LEFT;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  n_state = i_valid ? ST_X2 : ST_IDLE;
            ST_X2:    n_state = ST_T;
            ST_T:     n_state = ST_U;
            ST_U:     n_state = ST_S;
            ST_S:     n_state = ST_OFF;
            ST_OFF:   n_state = ST_ERR;
            ST_ERR:   n_state = ST_GAIN;
            ST_GAIN:  n_state = ST_RATE;
            ST_RATE:  n_state = ST_DPROD;
            ST_DPROD: n_state = ST_DEST;
            ST_DEST:  n_state = ST_DCOR;
            ST_DCOR:  n_state = ST_WHEEL;
            ST_WHEEL: n_state = ST_NUM;
            ST_NUM:   n_state = ST_DIV;
            ST_DIV:   n_state = (r_cnt == CW'(1)) ? ST_DONE : ST_DIV;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = i_valid ? ST_X2 : ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // sequencer strobes
    always_comb begin
        w_out_free = !r_o_valid || i_ready;
        w_out_load = 1'b0;
        w_pop      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_pop = i_valid;
            end
            ST_DONE: begin
                w_out_load = w_out_free;
                w_pop      = w_out_free && i_valid;
            end
            default: begin
                w_pop = 1'b0;
            end
        endcase
    end

    assign o_ready = w_pop;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath steps
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_pos   <= i_pos;
            r_neg_s <= i_neg_s;
            r_neg_c <= i_neg_c;
            r_x_s   <= 17'(i_ks) << (16 - QW);
            r_x_c   <= 17'(i_kc) << (16 - QW);
        end
        unique case (r_state)
            ST_X2: begin
                r_x2_s <= w_sq_s[32:16];
                r_x2_c <= w_sq_c[32:16];
            end
            ST_T: begin
                r_t_s <= SIN_B - {3'b0, w_cx_s[28:16]};
                r_t_c <= SIN_B - {3'b0, w_cx_c[28:16]};
            end
            ST_U: begin
                r_u_s <= SIN_A - w_xt_s[32:16];
                r_u_c <= SIN_A - w_xt_c[32:16];
            end
            ST_S: begin
                r_sin <= r_neg_s ? -$signed({1'b0, w_sm}) : $signed({1'b0, w_sm});
                r_cos <= r_neg_c ? -$signed({1'b0, w_cm}) : $signed({1'b0, w_cm});
            end
            ST_OFF: begin
                r_off <= w_psum[28:16];
            end
            ST_ERR: begin
                r_err <= w_esat;
            end
            ST_GAIN: begin
                r_gp <= $signed({1'b0, i_cfg.gain}) * r_err;
            end
            ST_RATE: begin
                r_rate <= w_rate;
            end
            ST_DPROD: begin
                r_dmag <= i_cfg.half_track * w_rabs;
                r_dneg <= r_rate[11];
            end
            ST_DEST: begin
                r_n  <= w_n;
                r_q0 <= w_qp[30:20];
            end
            ST_DCOR: begin
                r_d <= r_dneg ? -$signed({1'b0, w_dm}) : $signed({1'b0, w_dm});
            end
            ST_WHEEL: begin
                r_vl <= clamp_speed(w_sl, w_maxs13);
                r_vr <= clamp_speed(w_sr, w_maxs13);
            end
            ST_NUM: begin
                r_rem_l <= 11'(w_num_l >> NQE);
                r_rem_r <= 11'(w_num_r >> NQE);
                r_nlo_l <= w_num_l[NQE-1:0];
                r_nlo_r <= w_num_r[NQE-1:0];
                r_quo_l <= '0;
                r_quo_r <= '0;
                r_cnt   <= CW'(STEPS);
            end
            ST_DIV: begin
                r_rem_l <= w_st2_l[10:0];
                r_rem_r <= w_st2_r[10:0];
                r_nlo_l <= r_nlo_l << 2;
                r_nlo_r <= r_nlo_r << 2;
                r_quo_l <= NQE'({r_quo_l, w_st1_l[11], w_st2_l[11]});
                r_quo_r <= NQE'({r_quo_r, w_st1_r[11], w_st2_r[11]});
                r_cnt   <= r_cnt - 1'b1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_cmd   <= w_cmd;
            r_o_pwm   <= 8'(w_big);
            r_o_steer <= (w_cmd == CMD_FORWARD) ? 9'(w_steer) : 9'sd0;
            r_o_rate  <= r_rate;
            r_o_vl    <= r_vl;
            r_o_vr    <= r_vr;
            r_o_err   <= r_err;
        end
    end

    assign o_valid = r_o_valid;
    assign o_cmd   = r_o_cmd;
    assign o_pwm   = r_o_pwm;
    assign o_steer = r_o_steer;
    assign o_rate  = r_o_rate;
    assign o_left  = r_o_vl;
    assign o_right = r_o_vr;
    assign o_err   = r_o_err;

`ifndef SYNTH
    // a delivered heading rate always lies within the limit
    a_rate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_rate <= 12'sd2000) && (r_o_rate >= -12'sd2000))
        else $error("heading rate outside limit");

    // clamped wheel speeds stay within the maximum speed when the pwm numerators are formed
    a_wheel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NUM) |-> (13'(r_vl) <= w_maxs13) && (13'(r_vl) >= -w_maxs13)
                             && (13'(r_vr) <= w_maxs13) && (13'(r_vr) >= -w_maxs13))
        else $error("wheel speed outside clamp");

    // the pwm quotient never exceeds full scale
    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_quo_l <= NQE'(PWM_K)) && (r_quo_r <= NQE'(PWM_K)))
        else $error("pwm quotient above full scale");

    // steering is zero outside forward mode
    a_steer_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_cmd != CMD_FORWARD)) |-> (r_o_steer == 9'sd0))
        else $error("steering set outside forward mode");
`endif

endmodule

@@ src/wall_follow_drive_mixer.sv @@
// top level: configuration registers, front end, request queue and back-end sequencer
//
//  channel   direction  handshake                  payload
//  s         in         i_s_tvalid / o_s_tready    i_s_tdata: position, heading
//  m         out        o_m_tvalid / i_m_tready    o_m_tdata: command, pwm, steer, rate,
//                                                  left, right, error
//  cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  the back-end sequencer finishes each request before it takes the next one, and its
//  two-bit-per-cycle pwm divider forms both wheel quotients
//  the front end and the two-entry queue take requests while the back end works,
//  so up to three requests may be waiting behind the one in progress
//  a finished result waits in the output register; the sequencer stalls only on a full one
//  synchronous active-low reset clears control state and loads register defaults
module wall_follow_drive_mixer
    import wfdm_pkg::*;
#(
    parameter int unsigned PWM_MAX    = PWM_MAX_DEF,
    parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [31:0]          i_s_tdata,   // pos_lateral_mm[15:0], heading_angle[27:16]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [71:0]          o_m_tdata,   // drive_cmd[1:0], drive_pwm[9:2],
                                              // steer_pwm[18:10], turn_rate_mrad_s[30:19],
                                              // left_speed_mm_s[42:31],
                                              // right_speed_mm_s[54:43],
                                              // lateral_error_mm[70:55]
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [11:0]          i_cfg_data
);

    localparam int unsigned KW = ANGLE_BITS - 1;
    localparam int unsigned QD = 16 + 2 * KW + 2;

    t_cfg r_cfg;

    logic                 w_f_valid;
    logic                 w_f_ready;
    logic signed [15:0]   w_f_pos;
    logic [KW-1:0]        w_f_ks;
    logic [KW-1:0]        w_f_kc;
    logic                 w_f_neg_s;
    logic                 w_f_neg_c;
    logic [QD-1:0]        w_q_in;
    logic [QD-1:0]        w_q_out;
    logic                 w_q_valid;
    logic                 w_q_ready;
    logic [1:0]           w_cmd;
    logic [7:0]           w_pwm;
    logic signed [8:0]    w_steer;
    logic signed [11:0]   w_rate;
    logic signed [11:0]   w_left;
    logic signed [11:0]   w_right;
    logic signed [15:0]   w_err;

    // configuration register file
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_REF_OFFSET:  r_cfg.ref_offset  <= i_cfg_data;
                REG_GAIN:        r_cfg.gain        <= i_cfg_data;
                REG_BASE_SPEED:  r_cfg.base_speed  <= $signed(i_cfg_data);
                REG_MAX_SPEED:   r_cfg.max_speed   <= i_cfg_data[10:0];
                REG_SENSOR_FWD:  r_cfg.sensor_fwd  <= $signed(i_cfg_data[9:0]);
                REG_SENSOR_SIDE: r_cfg.sensor_side <= $signed(i_cfg_data[9:0]);
                REG_HALF_TRACK:  r_cfg.half_track  <= i_cfg_data[8:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // front end
    wfdm_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_pos     ($signed(i_s_tdata[15:0])),
        .i_heading (i_s_tdata[27:16]),
        .o_valid   (w_f_valid),
        .i_ready   (w_f_ready),
        .o_pos     (w_f_pos),
        .o_ks      (w_f_ks),
        .o_kc      (w_f_kc),
        .o_neg_s   (w_f_neg_s),
        .o_neg_c   (w_f_neg_c)
    );

    // request queue
    assign w_q_in = {w_f_pos, w_f_ks, w_f_kc, w_f_neg_s, w_f_neg_c};

    wfdm_queue #(
        .WIDTH (QD)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_q_in),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_out)
    );

    // back end
    wfdm_back #(
        .PWM_MAX    (PWM_MAX),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_pos   ($signed(w_q_out[QD-1:QD-16])),
        .i_ks    (w_q_out[2*KW+1:KW+2]),
        .i_kc    (w_q_out[KW+1:2]),
        .i_neg_s (w_q_out[1]),
        .i_neg_c (w_q_out[0]),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_cmd   (w_cmd),
        .o_pwm   (w_pwm),
        .o_steer (w_steer),
        .o_rate  (w_rate),
        .o_left  (w_left),
        .o_right (w_right),
        .o_err   (w_err)
    );

    // result packing
    assign o_m_tdata = {1'b0, w_err, w_right, w_left, w_rate, w_steer, w_pwm, w_cmd};

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the wall-following drive mixer
module tb
    import wfdm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_REGS = 7;
    localparam int QTR_BITS = ANGLE_BITS_DEF - 2;
    localparam int QTR_SIZE = 1 << QTR_BITS;
    // index past the register list, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    // one mixer result, split into its fields
    typedef struct {
        t_drive_cmd         cmd;
        logic [7:0]         pwm;
        logic signed [8:0]  steer;
        logic signed [11:0] rate;
        logic signed [11:0] left;
        logic signed [11:0] right;
        logic signed [15:0] err;
    } t_mix_result;

    // predicts mixer outputs and checks them in order
    class drive_mix_scoreboard;
        t_mix_result expected_q [$];
        int unsigned mismatches;
        longint ref_mm, gain, base_mm_s, max_mm_s, fwd_mm, side_mm, half_track;

        function new();
            ref_mm     = CFG_RESET.ref_offset;
            gain       = CFG_RESET.gain;
            base_mm_s  = $signed(CFG_RESET.base_speed);
            max_mm_s   = CFG_RESET.max_speed;
            fwd_mm     = $signed(CFG_RESET.sensor_fwd);
            side_mm    = $signed(CFG_RESET.sensor_side);
            half_track = CFG_RESET.half_track;
            mismatches = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [11:0] val);
            case (idx)
                REG_REF_OFFSET:  ref_mm = val;
                REG_GAIN:        gain = val;
                REG_BASE_SPEED:  base_mm_s = $signed(val);
                REG_MAX_SPEED:   max_mm_s = val[10:0];
                REG_SENSOR_FWD:  fwd_mm = $signed(val[9:0]);
                REG_SENSOR_SIDE: side_mm = $signed(val[9:0]);
                REG_HALF_TRACK:  half_track = val[8:0];
                default: ;
            endcase
        endfunction

        function longint clip(input longint v, input longint lo, input longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // divide rounding half away from zero, dv > 0
        function longint round_div(input longint v, input longint dv);
            return (v >= 0) ? (v + dv / 2) / dv : -((-v + dv / 2) / dv);
        endfunction

        // q16 sine from the quarter-wave polynomial, folded by quadrant
        function longint sine_q16(input int unsigned ang);
            int unsigned quad, k;
            longint unsigned x, x2, t, u, s;
            quad = (ang >> QTR_BITS) & 3;
            k = ang & (QTR_SIZE - 1);
            if (quad & 1)
                k = QTR_SIZE - k;
            x  = longint'(k) << (16 - QTR_BITS);
            x2 = (x * x) >> 16;
            t  = SIN_B - ((SIN_C * x2) >> 16);
            u  = SIN_A - ((x2 * t) >> 16);
            s  = (x * u) >> 16;
            if (s > 65536)
                s = 65536;
            return (quad & 2) ? -longint'(s) : longint'(s);
        endfunction

        function longint pwm_of(input longint v, input longint full);
            longint p;
            p = (v < 0 ? -v : v) * longint'(PWM_MAX_DEF) / full;
            return (p > longint'(PWM_MAX_DEF)) ? longint'(PWM_MAX_DEF) : p;
        endfunction

        function t_mix_result predict(input logic [15:0] pos, input logic [11:0] hdg);
            t_mix_result r;
            longint s, c, ys, err, rate, d, maxs, vl, vr, pl, pr;
            s = sine_q16(hdg);
            c = sine_q16(hdg + QTR_SIZE);
            // sensor lateral position, rotated offset rounded to mm
            ys = longint'($signed(pos)) + ((s * fwd_mm + c * side_mm + 32768) >>> 16);
            err = clip(ref_mm - ys, -32768, 32767);
            rate = clip(round_div(gain * err, 256), -longint'(RATE_LIMIT),
                        longint'(RATE_LIMIT));
            // zero max speed behaves as one
            maxs = (max_mm_s == 0) ? 1 : max_mm_s;
            d  = round_div(half_track * rate, 1000);
            vl = clip(base_mm_s - d, -maxs, maxs);
            vr = clip(base_mm_s + d, -maxs, maxs);
            pl = pwm_of(vl, maxs);
            pr = pwm_of(vr, maxs);
            r.pwm   = 8'(pl > pr ? pl : pr);
            r.steer = '0;
            // steer only in forward mode, mixed signs pick the turn side
            if (vl >= 0 && vr >= 0) begin
                r.cmd   = CMD_FORWARD;
                r.steer = 9'(pr - pl);
            end else if (vl < 0 && vr < 0) begin
                r.cmd = CMD_BACKWARD;
            end else if (vl > vr) begin
                r.cmd = CMD_RIGHT;
            end else begin
                r.cmd = CMD_LEFT;
            end
            r.rate  = 12'(rate);
            r.left  = 12'(vl);
            r.right = 12'(vr);
            r.err   = 16'(err);
            return r;
        endfunction

        function void note_request(input logic [15:0] pos, input logic [11:0] hdg);
            expected_q.push_back(predict(pos, hdg));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(input logic [71:0] bus);
            t_mix_result got, want;
            got.cmd   = t_drive_cmd'(bus[1:0]);
            got.pwm   = bus[9:2];
            got.steer = bus[18:10];
            got.rate  = bus[30:19];
            got.left  = bus[42:31];
            got.right = bus[54:43];
            got.err   = bus[70:55];
            if (expected_q.size() == 0) begin
                report("result with no request waiting");
            end else begin
                want = expected_q.pop_front();
                if (got.cmd !== want.cmd)
                    report($sformatf("drive_cmd want %0d got %0d", want.cmd, got.cmd));
                if (got.pwm !== want.pwm)
                    report($sformatf("drive_pwm want %0d got %0d", want.pwm, got.pwm));
                if (got.steer !== want.steer)
                    report($sformatf("steer_pwm want %0d got %0d", want.steer, got.steer));
                if (got.rate !== want.rate)
                    report($sformatf("turn_rate want %0d got %0d", want.rate, got.rate));
                if (got.left !== want.left)
                    report($sformatf("left_speed want %0d got %0d", want.left, got.left));
                if (got.right !== want.right)
                    report($sformatf("right_speed want %0d got %0d", want.right, got.right));
                if (got.err !== want.err)
                    report($sformatf("lateral_error want %0d got %0d", want.err, got.err));
            end
        endtask
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [31:0]          i_s_tdata   = '0;   // pos_lateral_mm[15:0], heading_angle[27:16]
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [71:0]          o_m_tdata;          // cmd, pwm, steer, rate, left, right, error
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [11:0]          i_cfg_data  = '0;

    bit idle_on = 1'b1;
    drive_mix_scoreboard sb = new();

    wall_follow_drive_mixer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // send one request, with an optional idle burst ahead of it
    task automatic send_item(input logic [15:0] pos, input logic [11:0] hdg);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0000, hdg, pos};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(pos, hdg);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [11:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    // write every register, optionally poke the unused index first
    task automatic apply_setting(input logic [11:0] vals [NUM_REGS], input bit poke_spare);
        if (poke_spare)
            write_reg(REG_SPARE, 12'($urandom));
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(t_reg_idx'(i), vals[i]);
        i_cfg_valid <= 1'b0;
    endtask

    // stop sending and wait for every outstanding result
    task automatic finish_phase();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // result sink with random stall bursts
    initial begin : sink_ready
        int n;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 5);
                i_m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata);
    end

    initial begin : stimulus
        // register order: ref, gain, base, max, fwd, side, half track
        logic [11:0] vals [NUM_REGS];
        logic [15:0] pos;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: on target, small steer, both turns, high saturation
        send_item(16'sd500, 12'd0);
        send_item(16'sd400, 12'd1024);
        send_item(16'sd20000, 12'd0);
        send_item(-16'sd20000, 12'd2048);
        send_item(16'h8000, 12'hFFF);
        finish_phase();

        // backward drive, sensor rotated through every quadrant, low saturation
        vals = '{12'd0, 12'd4095, 12'h830, 12'd2000, 12'd500, 12'd500, 12'd500};
        apply_setting(vals, 1'b1);
        send_item(16'h7FFF, 12'd512);
        send_item(16'd0, 12'd0);
        send_item(16'd0, 12'd1023);
        send_item(16'd0, 12'd1024);
        send_item(16'd0, 12'd1025);
        send_item(16'd0, 12'd2048);
        send_item(16'd0, 12'd3072);
        send_item(16'd0, 12'hFFF);
        send_item(16'hFFFF, 12'd2047);
        finish_phase();

        // zero max speed acts as one
        vals = '{12'd100, 12'd256, 12'd0, 12'd0, 12'hFFD, 12'd7, 12'd1};
        apply_setting(vals, 1'b0);
        send_item(16'd100, 12'd0);
        send_item(-16'sd20000, 12'd1000);
        send_item(16'sd20000, 12'd3000);
        send_item(16'd0, 12'd2500);
        finish_phase();

        // registers at the ends of their widths
        vals = '{12'hFFF, 12'hFFF, 12'h800, 12'hFFF, 12'h200, 12'h1FF, 12'hFFF};
        apply_setting(vals, 1'b1);
        send_item(16'h8000, 12'hFFF);
        send_item(16'h7FFF, 12'h800);
        send_item(16'd0, 12'h400);
        send_item(16'hAAAA, 12'h555);
        finish_phase();

        // random settings, positions mostly around the target
        for (int ph = 0; ph < 8; ph++) begin
            vals[REG_REF_OFFSET]  = 12'($urandom_range(0, 4000));
            vals[REG_GAIN]        = $urandom_range(0, 1) ? 12'($urandom_range(0, 300))
                                                         : 12'($urandom_range(0, 4095));
            vals[REG_BASE_SPEED]  = 12'(int'($urandom_range(0, 4000)) - 2000);
            vals[REG_MAX_SPEED]   = 12'($urandom_range(1, 2000));
            vals[REG_SENSOR_FWD]  = 12'(int'($urandom_range(0, 1000)) - 500);
            vals[REG_SENSOR_SIDE] = 12'(int'($urandom_range(0, 1000)) - 500);
            vals[REG_HALF_TRACK]  = 12'($urandom_range(1, 500));
            // now and then one register gets raw bits
            if ($urandom_range(0, 3) == 0)
                vals[$urandom_range(0, NUM_REGS - 1)] = 12'($urandom);
            apply_setting(vals, ph % 2 == 0);
            idle_on = (ph != 3) && (ph != 7);
            repeat (160) begin
                if ($urandom_range(0, 4) == 0)
                    pos = 16'($urandom);
                else
                    pos = 16'(int'(vals[REG_REF_OFFSET]) + int'($urandom_range(0, 6000))
                              - 3000);
                send_item(pos, 12'($urandom));
            end
            finish_phase();
        end

        // let any stray result show up
        repeat (40) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial begin
        #(3_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
